// File: rtl/mpbf_pkg.sv
`default_nettype none

package mpbf_pkg;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLOSE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_PIPE = 2'd1,
        STAT_NO_FREE  = 2'd2
    } t_status;

    localparam logic [8:0] CAP_LIMIT = 9'd504;
    localparam logic [3:0] WRITE_MAX = 4'd8;

    typedef struct packed {
        t_req        req_type;
        logic [3:0]  pipe_id;
        logic [9:0]  length;
        logic [63:0] data;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [8:0]  value;
        logic [63:0] read_data;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WR,
        S_RD,
        S_RD_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic wr_step;
        logic wr_fin;
        logic rd_issue;
        logic rd_pack;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic go_wr;
        logic go_rd;
        logic wr_more;
        logic word_end;
        logic more_words;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/multi_pipe_byte_fifo_table_unit.sv
// Table of byte pipes, each a circular byte buffer in a shared byte-wide memory.
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_item): create,
// write of up to eight bytes, read of up to read_cap (at most 504) bytes, and close.
// Results leave on the output channel (o_out_valid, i_out_stall, o_out_item); a
// read gives one result per 8-byte word, and the final result of every request
// has last set. The read_cap register is written on the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data); the user must do so only while no request
// is in progress, as the block itself does not enforce it. One request is handled
// at a time. A write, or each word of a read, moves one byte per cycle through the
// single memory port; between read words the block waits until the result is
// loaded into the output register. A new request is accepted as soon as the
// previous one has handed its final result to the output register.
// When the receiver stalls, the result waits in the output register and the block
// pauses before loading the next one. Reset clears all pipes to inactive and empty,
// sets read_cap to 504 and empties the output register; no memory clearing is needed.
`default_nettype none

module multi_pipe_byte_fifo_table_unit #(
    parameter int NUM_PIPES = 8,
    parameter int BUF_BYTES = 512
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mpbf_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mpbf_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [8:0]          i_cfg_data
);

    mpbf_pkg::t_cmd  w_cmd;
    mpbf_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mpbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mpbf_dp #(
        .NUM_PIPES (NUM_PIPES),
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: rtl/mpbf_ctrl.sv
`default_nettype none

module mpbf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire mpbf_pkg::t_stat i_stat,
    output mpbf_pkg::t_cmd       o_cmd
);

    mpbf_pkg::t_state r_state;
    mpbf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpbf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpbf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mpbf_pkg::S_EXEC;
                end
            end
            mpbf_pkg::S_EXEC: begin
                if (i_stat.go_wr) begin
                    n_state = mpbf_pkg::S_WR;
                end else if (i_stat.go_rd) begin
                    n_state = mpbf_pkg::S_RD;
                end else begin
                    n_state = mpbf_pkg::S_EMIT;
                end
            end
            mpbf_pkg::S_WR: begin
                if (!i_stat.wr_more) begin
                    n_state = mpbf_pkg::S_EMIT;
                end
            end
            mpbf_pkg::S_RD: begin
                if (i_stat.word_end) begin
                    n_state = mpbf_pkg::S_RD_DRAIN;
                end
            end
            mpbf_pkg::S_RD_DRAIN: begin
                n_state = mpbf_pkg::S_EMIT;
            end
            mpbf_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.more_words ? mpbf_pkg::S_RD : mpbf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpbf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            mpbf_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            mpbf_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            mpbf_pkg::S_WR: begin
                o_cmd.wr_step = i_stat.wr_more;
                o_cmd.wr_fin  = !i_stat.wr_more;
            end
            mpbf_pkg::S_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            mpbf_pkg::S_RD_DRAIN: begin
                o_cmd.rd_pack = 1'b1;
            end
            mpbf_pkg::S_EMIT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mpbf_dp.sv
`default_nettype none

module mpbf_dp #(
    parameter int NUM_PIPES = 8,
    parameter int BUF_BYTES = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mpbf_pkg::t_in_item i_in_item,
    input  wire logic               i_cfg_valid,
    input  wire logic [8:0]         i_cfg_data,
    input  wire mpbf_pkg::t_cmd     i_cmd,
    output mpbf_pkg::t_stat         o_stat,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output mpbf_pkg::t_out_item     o_out_item
);

    localparam int IW    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int HW    = $clog2(BUF_BYTES);
    localparam int CW    = $clog2(BUF_BYTES + 1);
    localparam int SW    = CW + 1;
    localparam int DEPTH = NUM_PIPES * BUF_BYTES;
    localparam int AW    = $clog2(DEPTH);

    mpbf_pkg::t_in_item  r_req;
    mpbf_pkg::t_out_item r_res;
    mpbf_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [8:0]          r_read_cap;

    logic                r_active [NUM_PIPES];
    logic [HW-1:0]       r_head   [NUM_PIPES];
    logic [CW-1:0]       r_count  [NUM_PIPES];
    logic [7:0]          r_mem    [DEPTH];
    logic [7:0]          r_mem_q;

    logic                r_rd_v;
    logic [2:0]          r_rd_lane;
    logic [2:0]          r_lane;
    logic [8:0]          r_left;
    logic [8:0]          r_rlen;
    logic [3:0]          r_n;
    logic [3:0]          r_done;
    logic [63:0]         r_data;
    logic [HW-1:0]       r_pos;
    logic [63:0]         r_word;

    logic [IW-1:0]       w_idx;
    logic                w_valid;
    logic [HW-1:0]       w_head;
    logic [CW-1:0]       w_count;
    logic                w_found;
    logic [IW-1:0]       w_free;
    logic [8:0]          w_cap;
    logic [8:0]          w_lim;
    logic [8:0]          w_rlen;
    logic [SW-1:0]       w_sum;
    logic [HW-1:0]       w_start;
    logic [HW-1:0]       w_pos_inc;
    logic [HW-1:0]       w_head_inc;
    logic [AW-1:0]       w_base;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [63:0]         w_word_acc;
    logic [3:0]          w_n;
    logic                w_is_rd;

    assign w_idx   = r_req.pipe_id[IW-1:0];
    assign w_valid = ({1'b0, r_req.pipe_id} < 5'(NUM_PIPES)) && r_active[w_idx];
    assign w_head  = r_head[w_idx];
    assign w_count = r_count[w_idx];
    assign w_is_rd = (r_req.req_type == mpbf_pkg::REQ_READ) && w_valid;

    always_comb begin
        w_found = 1'b0;
        w_free  = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_found = 1'b1;
                w_free  = IW'(i);
            end
        end
    end

    assign w_cap  = (r_read_cap > mpbf_pkg::CAP_LIMIT) ? mpbf_pkg::CAP_LIMIT : r_read_cap;
    assign w_lim  = (r_req.length < {1'b0, w_cap}) ? r_req.length[8:0] : w_cap;
    assign w_rlen = (16'(w_count) < 16'(w_lim)) ? 9'(w_count) : w_lim;
    assign w_n    = (r_req.length > 10'(mpbf_pkg::WRITE_MAX)) ? mpbf_pkg::WRITE_MAX
                                                              : r_req.length[3:0];

    assign w_sum      = SW'(w_head) + SW'(w_count);
    assign w_start    = (w_sum >= SW'(BUF_BYTES)) ? HW'(w_sum - SW'(BUF_BYTES)) : HW'(w_sum);
    assign w_pos_inc  = (r_pos == HW'(BUF_BYTES - 1)) ? '0 : r_pos + 1'b1;
    assign w_head_inc = (w_head == HW'(BUF_BYTES - 1)) ? '0 : w_head + 1'b1;

    assign w_base  = AW'(w_idx) * AW'(BUF_BYTES);
    assign w_waddr = w_base + AW'(r_pos);
    assign w_raddr = w_base + AW'(w_head);

    always_comb begin
        w_word_acc = r_word;
        if (r_rd_v) begin
            w_word_acc[r_rd_lane*8 +: 8] = r_mem_q;
        end
    end

    assign o_stat.go_wr      = (r_req.req_type == mpbf_pkg::REQ_WRITE) && w_valid;
    assign o_stat.go_rd      = w_is_rd && (w_rlen != 9'd0);
    assign o_stat.wr_more    = (r_done < r_n) && (w_count < CW'(BUF_BYTES));
    assign o_stat.word_end   = (r_lane == 3'd7) || (r_left == 9'd1);
    assign o_stat.more_words = (r_left != 9'd0);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_active[i] <= 1'b0;
                r_head[i]   <= '0;
                r_count[i]  <= '0;
            end
        end else begin
            if (i_cmd.exec) begin
                if ((r_req.req_type == mpbf_pkg::REQ_CREATE) && w_found) begin
                    r_active[w_free] <= 1'b1;
                    r_head[w_free]   <= '0;
                    r_count[w_free]  <= '0;
                end
                if ((r_req.req_type == mpbf_pkg::REQ_CLOSE) && w_valid) begin
                    r_active[w_idx] <= 1'b0;
                end
            end
            if (i_cmd.wr_step) begin
                r_count[w_idx] <= w_count + 1'b1;
            end
            if (i_cmd.rd_issue) begin
                r_head[w_idx]  <= w_head_inc;
                r_count[w_idx] <= w_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_step) begin
            r_mem[w_waddr] <= r_data[7:0];
        end
        if (i_cmd.rd_issue) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_cap  <= mpbf_pkg::CAP_LIMIT;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_read_cap <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_rd_v <= i_cmd.rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_item;
        end
        if (i_cmd.exec) begin
            if (r_req.req_type == mpbf_pkg::REQ_CREATE) begin
                r_res.status <= w_found ? mpbf_pkg::STAT_OK : mpbf_pkg::STAT_NO_FREE;
                r_res.value  <= w_found ? 9'(w_free) : 9'd0;
            end else if ((r_req.req_type == mpbf_pkg::REQ_WRITE) && !w_valid) begin
                r_res.status <= mpbf_pkg::STAT_BAD_PIPE;
                r_res.value  <= 9'd0;
            end else begin
                r_res.status <= mpbf_pkg::STAT_OK;
                r_res.value  <= 9'd0;
            end
            r_res.read_data <= 64'd0;
            r_res.last      <= 1'b1;
            r_left          <= w_is_rd ? w_rlen : 9'd0;
            r_rlen          <= w_rlen;
            r_n             <= w_n;
            r_done          <= 4'd0;
            r_data          <= r_req.data;
            r_pos           <= w_start;
            r_lane          <= 3'd0;
        end
        if (i_cmd.wr_step) begin
            r_data <= r_data >> 8;
            r_pos  <= w_pos_inc;
            r_done <= r_done + 1'b1;
        end
        if (i_cmd.wr_fin) begin
            r_res.status    <= mpbf_pkg::STAT_OK;
            r_res.value     <= 9'(r_done);
            r_res.read_data <= 64'd0;
            r_res.last      <= 1'b1;
        end
        if (i_cmd.rd_issue) begin
            r_rd_lane <= r_lane;
            r_lane    <= r_lane + 1'b1;
            r_left    <= r_left - 1'b1;
        end
        if (i_cmd.exec || i_cmd.rd_pack) begin
            r_word <= 64'd0;
        end else begin
            r_word <= w_word_acc;
        end
        if (i_cmd.rd_pack) begin
            r_res.status    <= mpbf_pkg::STAT_OK;
            r_res.value     <= r_rlen;
            r_res.read_data <= w_word_acc;
            r_res.last      <= (r_left == 9'd0);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/mpbf_chk.sv
`default_nettype none

module mpbf_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire mpbf_pkg::t_out_item o_out_item
);

    // A result held back by the receiver stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output item changed while stalled");

    // Reset leaves the block ready for a request with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && !o_out_valid))
        else $error("block not idle after reset");

    // An accepted request occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted back to back");

    // No new request is taken while a read still has words to deliver.
    a_no_accept_mid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> o_in_stall)
        else $error("request accepted in the middle of a read");

    // Only reads give more than one result, and they never report an error.
    a_mid_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> (o_out_item.status == mpbf_pkg::STAT_OK))
        else $error("non-final result with error status");

endmodule

bind multi_pipe_byte_fifo_table_unit mpbf_chk u_mpbf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// File: tb/sv/mpbf_checker.sv
`timescale 1ns / 1ps

module mpbf_checker #(
    parameter int PIPES = 8,
    parameter int DEPTH = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mpbf_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mpbf_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [8:0]          i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    logic                pipe_on   [PIPES];
    logic [8:0]          pipe_head [PIPES];
    logic [9:0]          pipe_fill [PIPES];
    logic [7:0]          pipe_mem  [PIPES][DEPTH];
    logic [8:0]          read_cap;
    mpbf_pkg::t_out_item results_due [$];
    int                  mismatches = 0;
    int                  due_count = 0;

    assign o_errors  = mismatches;
    assign o_pending = due_count;

    task automatic predict_request(input mpbf_pkg::t_in_item req);
        mpbf_pkg::t_out_item res;
        bit          ok;
        bit          found;
        int          id;
        int          span;
        int          moved;
        int          cap;
        int          pos;
        logic [63:0] word;
        id = req.pipe_id;
        ok = 1'b0;
        if (id < PIPES) ok = pipe_on[id];
        res = '0;
        res.status = mpbf_pkg::STAT_OK;
        res.last = 1'b1;
        word = '0;
        case (req.req_type)
            mpbf_pkg::REQ_CREATE: begin
                found = 1'b0;
                res.status = mpbf_pkg::STAT_NO_FREE;
                for (int i = 0; i < PIPES; i++) begin
                    if (!found && !pipe_on[i]) begin
                        found = 1'b1;
                        pipe_on[i] = 1'b1;
                        pipe_head[i] = '0;
                        pipe_fill[i] = '0;
                        res.status = mpbf_pkg::STAT_OK;
                        res.value = 9'(i);
                    end
                end
                results_due.push_back(res);
            end
            mpbf_pkg::REQ_WRITE: begin
                if (!ok) begin
                    res.status = mpbf_pkg::STAT_BAD_PIPE;
                end else begin
                    span = (req.length > mpbf_pkg::WRITE_MAX) ? int'(mpbf_pkg::WRITE_MAX)
                                                              : int'(req.length);
                    moved = 0;
                    while (moved < span && int'(pipe_fill[id]) < DEPTH) begin
                        pos = (int'(pipe_head[id]) + int'(pipe_fill[id])) % DEPTH;
                        pipe_mem[id][pos] = req.data[moved*8 +: 8];
                        pipe_fill[id] = pipe_fill[id] + 10'd1;
                        moved++;
                    end
                    res.value = 9'(moved);
                end
                results_due.push_back(res);
            end
            mpbf_pkg::REQ_READ: begin
                span = 0;
                if (ok) begin
                    cap = (read_cap > mpbf_pkg::CAP_LIMIT) ? int'(mpbf_pkg::CAP_LIMIT)
                                                           : int'(read_cap);
                    span = pipe_fill[id];
                    if (int'(req.length) < span) span = req.length;
                    if (cap < span) span = cap;
                end
                if (span == 0) begin
                    results_due.push_back(res);
                end else begin
                    for (int i = 0; i < span; i++) begin
                        pos = (int'(pipe_head[id]) + i) % DEPTH;
                        word |= 64'(pipe_mem[id][pos]) << (8 * (i % 8));
                        if (i % 8 == 7 || i == span - 1) begin
                            res.value = 9'(span);
                            res.read_data = word;
                            res.last = (i == span - 1);
                            results_due.push_back(res);
                            word = '0;
                        end
                    end
                    pipe_head[id] = 9'((int'(pipe_head[id]) + span) % DEPTH);
                    pipe_fill[id] = pipe_fill[id] - 10'(span);
                end
            end
            default: begin
                if (ok) pipe_on[id] = 1'b0;
                results_due.push_back(res);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        mpbf_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < PIPES; i++) begin
                pipe_on[i] = 1'b0;
                pipe_head[i] = '0;
                pipe_fill[i] = '0;
            end
            read_cap = mpbf_pkg::CAP_LIMIT;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected item status %0d value %0d data %h last %b",
                                 $realtime, i_out_item.status, i_out_item.value,
                                 i_out_item.read_data, i_out_item.last);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (i_out_item.status !== want.status || i_out_item.value !== want.value ||
                        i_out_item.read_data !== want.read_data ||
                        i_out_item.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected status %0d value %0d data %h last %b",
                                     $realtime, want.status, want.value, want.read_data,
                                     want.last);
                            $display("%0t:      got status %0d value %0d data %h last %b",
                                     $realtime, i_out_item.status, i_out_item.value,
                                     i_out_item.read_data, i_out_item.last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in_item);
            if (i_cfg_valid && i_cfg_ready) read_cap = i_cfg_data;
        end
        due_count = results_due.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    mpbf_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    mpbf_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [8:0]          cfg_data = '0;
    int                  fail_count;
    int                  pending;
    bit                  calm = 1'b0;

    always #5 clk = ~clk;

    multi_pipe_byte_fifo_table_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mpbf_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending)
    );

    function automatic mpbf_pkg::t_in_item mk(mpbf_pkg::t_req kind, logic [3:0] id,
                                              logic [9:0] len, logic [63:0] bytes);
        mpbf_pkg::t_in_item it;
        it.req_type = kind;
        it.pipe_id = id;
        it.length = len;
        it.data = bytes;
        return it;
    endfunction

    function automatic mpbf_pkg::t_in_item random_request();
        mpbf_pkg::t_in_item it;
        int                 pick;
        int                 sub;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 19);
        it.data = {$urandom, $urandom};
        it.length = 10'($urandom);
        it.pipe_id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 7));
        if (pick < 10) begin
            it.req_type = mpbf_pkg::REQ_CREATE;
        end else if (pick < 55) begin
            it.req_type = mpbf_pkg::REQ_WRITE;
            if (sub == 0) it.length = 10'($urandom_range(9, 1023));
            else if (sub < 5) it.length = 10'd8;
            else it.length = 10'($urandom_range(0, 8));
        end else if (pick < 90) begin
            it.req_type = mpbf_pkg::REQ_READ;
            if (sub < 14) it.length = 10'($urandom_range(0, 24));
            else if (sub < 18) it.length = 10'($urandom_range(0, 1023));
            else it.length = 10'd1023;
        end else begin
            it.req_type = mpbf_pkg::REQ_CLOSE;
        end
        return it;
    endfunction

    task automatic send_req(input mpbf_pkg::t_in_item it);
        int pause;
        pause = calm ? 0 : $urandom_range(0, 3);
        if (pause > 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_cap(input logic [8:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        do @(posedge clk); while (!rst_n);
        forever begin
            int hold;
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [8:0] caps [7];
        int         p;
        caps = '{9'd0, 9'd1, 9'd8, 9'd9, 9'd63, 9'd504, 9'd300};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_req(mk(mpbf_pkg::REQ_READ, 4'd0, 10'd8, '0));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd0, 10'd8, {$urandom, $urandom}));
        send_req(mk(mpbf_pkg::REQ_CLOSE, 4'd0, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd15, 10'd8, '1));
        send_req(mk(mpbf_pkg::REQ_READ, 4'd15, 10'd1023, '1));
        send_req(mk(mpbf_pkg::REQ_CLOSE, 4'd9, 10'd0, '0));
        repeat (9) send_req(mk(mpbf_pkg::REQ_CREATE, 4'd0, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd0, 10'd8, '1));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd0, 10'd1023, {$urandom, $urandom}));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd0, 10'd0, '1));
        send_req(mk(mpbf_pkg::REQ_READ, 4'd0, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_READ, 4'd0, 10'd3, '0));
        send_req(mk(mpbf_pkg::REQ_READ, 4'd0, 10'd1023, '0));
        send_req(mk(mpbf_pkg::REQ_CLOSE, 4'd3, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_CREATE, 4'd0, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'd7, 10'd5, '0));
        send_req(mk(mpbf_pkg::REQ_READ, 4'd7, 10'd1023, '1));

        foreach (caps[i]) begin
            set_cap(caps[i]);
            calm = ($urandom_range(0, 3) == 0);
            repeat (22) send_req(random_request());
        end

        // Fill one pipe past full, drain the largest read, then wrap the buffer.
        set_cap(9'd511);
        calm = 1'b0;
        p = $urandom_range(0, 7);
        send_req(mk(mpbf_pkg::REQ_CLOSE, 4'(p), 10'd0, '0));
        repeat (8) send_req(mk(mpbf_pkg::REQ_CREATE, 4'd0, 10'd0, '0));
        send_req(mk(mpbf_pkg::REQ_WRITE, 4'(p), 10'd5, {$urandom, $urandom}));
        repeat (65) send_req(mk(mpbf_pkg::REQ_WRITE, 4'(p), 10'd8, {$urandom, $urandom}));
        wait_drained();
        send_req(mk(mpbf_pkg::REQ_READ, 4'(p), 10'd1023, '0));
        repeat (4) send_req(mk(mpbf_pkg::REQ_WRITE, 4'(p), 10'd8, {$urandom, $urandom}));
        send_req(mk(mpbf_pkg::REQ_READ, 4'(p), 10'd1023, '0));

        set_cap(9'd505);
        calm = 1'b1;
        repeat (22) send_req(random_request());

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mpbf_pkg.sv
rtl/mpbf_ctrl.sv
rtl/mpbf_dp.sv
rtl/multi_pipe_byte_fifo_table_unit.sv
rtl/mpbf_chk.sv
tb/sv/mpbf_checker.sv
tb/sv/tb.sv
